[src/markup_to_ansi_translator_core_macros.svh]
// assertion helpers shared by the rtl
`ifndef MARKUP_TO_ANSI_TRANSLATOR_CORE_MACROS_SVH
`define MARKUP_TO_ANSI_TRANSLATOR_CORE_MACROS_SVH

// implication checked on every clock outside reset
`define MTA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never be seen outside reset
`define MTA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[src/mta_pkg.sv]
package mta_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_word_t;

  typedef enum logic [2:0] {
    RepQuote   = 3'd0,
    RepNewline = 3'd1,
    RepCloseB  = 3'd2,
    RepCloseI  = 3'd3,
    RepOpenB   = 3'd4,
    RepOpenI   = 3'd5
  } rep_e;

  localparam int unsigned NumPatterns = 6;
  localparam logic [7:0]  EscByte     = 8'h1B;

  // classified result of one input word
  typedef struct packed {
    logic [2:0]      nlit;
    logic [3:0][7:0] lit;
    logic            has_rep;
    rep_e            rep;
    logic            last;
  } rec_t;

  function automatic logic [3:0][7:0] pat_bytes(rep_e p);
    logic [3:0][7:0] r;
    r = '0;
    unique case (p)
      RepQuote:   begin r[0] = 8'h22; r[1] = 8'h22; end
      RepNewline: begin r[0] = 8'h5C; r[1] = 8'h6E; end
      RepCloseB:  begin r[0] = 8'h3C; r[1] = 8'h2F; r[2] = 8'h62; r[3] = 8'h3E; end
      RepCloseI:  begin r[0] = 8'h3C; r[1] = 8'h2F; r[2] = 8'h69; r[3] = 8'h3E; end
      RepOpenB:   begin r[0] = 8'h3C; r[1] = 8'h62; r[2] = 8'h3E; end
      RepOpenI:   begin r[0] = 8'h3C; r[1] = 8'h69; r[2] = 8'h3E; end
      default:    r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pat_len(rep_e p);
    logic [2:0] r;
    unique case (p)
      RepQuote, RepNewline: r = 3'd2;
      RepCloseB, RepCloseI: r = 3'd4;
      RepOpenB, RepOpenI:   r = 3'd3;
      default:              r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0][7:0] rep_bytes(rep_e p);
    logic [3:0][7:0] r;
    r = '0;
    unique case (p)
      RepQuote:   r[0] = 8'h22;
      RepNewline: r[0] = 8'h0A;
      RepCloseB, RepCloseI: begin
        r[0] = EscByte; r[1] = 8'h5B; r[2] = 8'h30; r[3] = 8'h6D;
      end
      RepOpenB: begin
        r[0] = EscByte; r[1] = 8'h5B; r[2] = 8'h31; r[3] = 8'h6D;
      end
      RepOpenI: begin
        r[0] = EscByte; r[1] = 8'h5B; r[2] = 8'h33; r[3] = 8'h6D;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] rep_len(rep_e p);
    logic [2:0] r;
    unique case (p)
      RepQuote, RepNewline: r = 3'd1;
      RepCloseB, RepCloseI, RepOpenB, RepOpenI: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

[src/mta_front.sv]
module mta_front
  import mta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     full_i,
  output logic     push_o,
  output rec_t     rec_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [3:0][7:0] buf_v;
  logic [3:0][7:0] pb;
  logic [2:0]      n;
  logic [2:0]      pl;
  logic            stop, full, pref, eq;
  rep_e            full_id;
  rec_t            rec;
  logic            accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // greedy match over held bytes plus the new one, at most four rounds
  always_comb begin
    buf_v = '0;
    buf_v[2:0] = held_q;
    buf_v[cnt_q] = in_word_i.in_byte;
    n = {1'b0, cnt_q} + 3'd1;
    stop = 1'b0;
    full = 1'b0;
    pref = 1'b0;
    eq = 1'b0;
    pb = '0;
    pl = '0;
    full_id = RepQuote;
    rec = '0;
    rec.rep = RepQuote;
    rec.last = in_word_i.in_last;
    for (int it = 0; it < 4; it++) begin
      if (!stop && n != 3'd0) begin
        full = 1'b0;
        pref = 1'b0;
        full_id = RepQuote;
        for (int p = 0; p < NumPatterns; p++) begin
          pb = pat_bytes(rep_e'(3'(p)));
          pl = pat_len(rep_e'(3'(p)));
          eq = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (3'(k) < n && buf_v[k] != pb[k]) eq = 1'b0;
          end
          if (eq && n <= pl) begin
            if (n == pl) begin
              full = 1'b1;
              full_id = rep_e'(3'(p));
            end else begin
              pref = 1'b1;
            end
          end
        end
        if (full) begin
          rec.has_rep = 1'b1;
          rec.rep = full_id;
          n = 3'd0;
          stop = 1'b1;
        end else if (pref && !in_word_i.in_last) begin
          stop = 1'b1;
        end else begin
          // first byte cannot start a match any more: pass it through
          rec.lit[rec.nlit[1:0]] = buf_v[0];
          rec.nlit = rec.nlit + 3'd1;
          buf_v = {8'h00, buf_v[3:1]};
          n = n - 3'd1;
        end
      end
    end
    held_d = buf_v[2:0];
    cnt_d = n[1:0];
  end

  assign rec_o  = rec;
  assign push_o = accept && (rec.nlit != 3'd0 || rec.has_rep);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

[src/mta_fifo.sv]
module mta_fifo
  import mta_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t wdata_i,
  input  logic pop_i,
  output rec_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[src/mta_back.sv]
module mta_back
  import mta_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rec_t      rec_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic [1:0]      pos_q;
  logic            out_valid_q;
  out_word_t       out_q;
  logic [3:0]      total;
  logic [3:0][7:0] rb;
  logic [1:0]      rpos;
  logic [7:0]      cur_byte;
  logic            is_end;
  logic            load;

  always_comb begin
    total = {1'b0, rec_i.nlit};
    if (rec_i.has_rep) total = total + {1'b0, rep_len(rec_i.rep)};
    rb = rep_bytes(rec_i.rep);
    rpos = pos_q - rec_i.nlit[1:0];
    // literals go out first, then the replacement sequence
    if ({1'b0, pos_q} < rec_i.nlit) cur_byte = rec_i.lit[pos_q];
    else cur_byte = rb[rpos];
    is_end = (({2'b00, pos_q} + 4'd1) == total);
  end

  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      pos_q       <= is_end ? 2'd0 : pos_q + 2'd1;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= cur_byte;
      out_q.run_last <= is_end;
      out_q.text_end <= is_end && rec_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[src/markup_to_ansi_translator_core.sv]
// path: an accepted byte's record is written into the queue, then its words are registered at the output
// throughput: one input byte per cycle while each byte yields at most one word
//   and the output is not stalled; an escape sequence keeps the output serializer busy
//   for each of its words, and the input stalls once the two-entry queue in front of it fills
// reset: asynchronous, active low; clears held count, queue and output valid
`include "markup_to_ansi_translator_core_macros.svh"

module markup_to_ansi_translator_core
  import mta_pkg::*;
#(
  parameter int unsigned FifoDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic push, pop, full, empty;
  logic in_last_fire;
  rec_t wr_rec, rd_rec;

  assign in_last_fire = in_valid_i && in_ready_o && in_word_i.in_last;

  mta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (wr_rec)
  );

  mta_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_rec),
    .pop_i   (pop),
    .rdata_o (rd_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  mta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rd_rec),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  `MTA_ASSERT_NEVER(a_push_full, push && full, "queue pushed while full")
  `MTA_ASSERT_NEVER(a_pop_empty, pop && empty, "queue popped while empty")
  `MTA_ASSERT_IMP(a_last_flush, in_last_fire, push, "final word produced no output")

endmodule

[tb/tb_markup_to_ansi_translator_core.sv]
module tb_markup_to_ansi_translator_core;
  import mta_pkg::*;

  // tracks held partial match and the words each accepted byte should produce
  class ansi_rewrite_board;
    logic [7:0] held_text[$];
    out_word_t  expected_words[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function string match_text(rep_e p);
      case (p)
        RepQuote:   return "\"\"";
        RepNewline: return "\\n";
        RepCloseB:  return "</b>";
        RepCloseI:  return "</i>";
        RepOpenB:   return "<b>";
        default:    return "<i>";
      endcase
    endfunction

    function string replace_text(rep_e p);
      string s;
      case (p)
        RepQuote:             return "\"";
        RepNewline:           return "\n";
        RepCloseB, RepCloseI: s = "?[0m";
        RepOpenB:             s = "?[1m";
        default:              s = "?[3m";
      endcase
      s.putc(0, EscByte);
      return s;
    endfunction

    function void note_byte(in_word_t w);
      logic [7:0] scan[$];
      out_word_t  words[$];
      out_word_t  wd;
      string      pat;
      string      rep;
      int         hit;
      bit         partial;
      bit         same;
      scan = held_text;
      scan.push_back(w.in_byte);
      while (scan.size() > 0) begin
        hit = -1;
        partial = 1'b0;
        for (int p = 0; p < NumPatterns; p++) begin
          pat = match_text(rep_e'(p));
          if (scan.size() <= pat.len()) begin
            same = 1'b1;
            foreach (scan[k]) if (scan[k] != pat[k]) same = 1'b0;
            if (same) begin
              if (scan.size() == pat.len()) hit = p;
              else partial = 1'b1;
            end
          end
        end
        if (hit >= 0) begin
          rep = replace_text(rep_e'(hit));
          for (int k = 0; k < rep.len(); k++) begin
            wd = '0;
            wd.out_byte = rep[k];
            words.push_back(wd);
          end
          scan.delete();
          break;
        end
        // a live prefix waits for more bytes unless the text ends here
        if (partial && !w.in_last) break;
        wd = '0;
        wd.out_byte = scan.pop_front();
        words.push_back(wd);
      end
      held_text = scan;
      if (words.size() > 0) begin
        words[words.size() - 1].run_last = 1'b1;
        words[words.size() - 1].text_end = w.in_last;
      end
      foreach (words[k]) expected_words.push_back(words[k]);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("out_byte %0h arrived with no word expected", got.out_byte);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
        mismatches++;
      end
      if (got.text_end !== want.text_end) begin
        $error("text_end: expected %0b, got %0b", want.text_end, got.text_end);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  ansi_rewrite_board board;
  logic [7:0]        text_buf[$];
  int                bytes_sent;
  bit                sender_calm;
  bit                sink_calm;
  int                stall_left;

  string frag[20] = '{"\"", "\\", "n", "<", "/", "b", "i", ">", "\"\"", "\\n",
                      "</b>", "</i>", "<b>", "<i>", "</", "</b", "</i", "<b", "<i",
                      "<<i>"};

  markup_to_ansi_translator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  // check the outgoing word before noting the incoming one of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_word(out_word_o);
      if (in_valid_i && in_ready_o) board.note_byte(in_word_i);
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!sink_calm && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= '{in_byte: b, in_last: last};
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[k]) send_byte(text_buf[k], k == text_buf.size() - 1);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    text_buf.delete();
  endtask

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
  endtask

  task automatic wait_drained();
    while (board.expected_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int len;
    board       = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_ready_i = 1'b0;
    stall_left  = 0;
    bytes_sent  = 0;
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every tag, ending on a byte that completes a match
    add_str("\"\"\\n</b></i><b><i>");
    send_text();
    // zero and all-ones bytes, then a prefix cut off by the end of text
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    add_str("<</");
    send_text();
    wait_drained();

    while (bytes_sent < 380) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      sink_calm   = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      while (text_buf.size() < len) begin
        if ($urandom_range(0, 9) < 7) add_str(frag[$urandom_range(0, 19)]);
        else text_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
      if ($urandom_range(0, 14) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #7200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/mta_pkg.sv
src/mta_front.sv
src/mta_fifo.sv
src/mta_back.sv
src/markup_to_ansi_translator_core.sv
tb/tb_markup_to_ansi_translator_core.sv
